### rtl/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared widths, register indexes, reset values and types of the window
// median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 5;

  // effective image size is saturated into this range
  localparam int SIZE_MIN = 5;
  localparam int SIZE_MAX = 1024;

  localparam int   RST_WIDTH      = 640;
  localparam int   RST_HEIGHT     = 480;
  localparam logic RST_WINDOW_SEL = 1'b0;

  localparam int K_SMALL = 3;
  localparam int K_LARGE = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SELECT = CFG_IDX_W'(2);

  // where a window cell loads from on a shift
  typedef enum logic [1:0] {
    SRC_HOLD,
    SRC_RIGHT,
    SRC_COL
  } cell_src_e;

  typedef struct packed {
    logic [DIM_W-1:0] out_row;
    logic [DIM_W-1:0] out_col;
    logic             last_of_frame;
  } pos_t;

  typedef struct packed {
    pos_t             pos;
    logic [PIX_W-1:0] median_value;
  } res_t;

  // Cells left of the newest column take their right neighbor, the newest
  // column takes the incoming column, everything outside the window holds.
  function automatic cell_src_e cell_src(input int row, input int col, input int k);
    cell_src_e src;
    src = SRC_HOLD;
    if (row < k && col < k - 1) begin
      src = SRC_RIGHT;
    end else if (row < k && col == k - 1) begin
      src = SRC_COL;
    end
    return src;
  endfunction

endpackage

### rtl/wmf_if.sv
// ----------------------------------------------------------------------------
// wmf_if
// Valid/ready channels of the window median filter: pixel input, result
// output and configuration writes.
// ----------------------------------------------------------------------------
interface wmf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [wmf_pkg::PIX_W-1:0] pixel;
  logic                      start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface wmf_res_if;
  logic                      valid;
  logic                      ready;
  logic [wmf_pkg::DIM_W-1:0] out_row;
  logic [wmf_pkg::DIM_W-1:0] out_col;
  logic [wmf_pkg::PIX_W-1:0] median_value;
  logic                      last_of_frame;

  modport source (output valid, output out_row, output out_col, output median_value,
                  output last_of_frame, input ready);
  modport sink   (input valid, input out_row, input out_col, input median_value,
                  input last_of_frame, output ready);
endinterface

interface wmf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wmf_pkg::CFG_IDX_W-1:0] index;
  logic [wmf_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/window_median_filter.sv
// ----------------------------------------------------------------------------
// window_median_filter
// Streaming 3x3 / 5x5 median filter over 8-bit grey pixels in raster order.
// The block takes one pixel per clock cycle, whatever the window size, while
// the result output does not stall it: each pixel costs one read of every
// line store and one write of the current line at its column, and the
// window chain shifts one column per cycle. A result passes through the line
// store read, window shift, pairwise compare, rank count and output register
// stages after the pixel that completes its window, and is placed at the
// window's top-left position. Pixels whose window is not complete, and
// border positions no window covers, give no result. Line stores are not
// cleared after reset; a frame's first rows fill them before results use them.
// ----------------------------------------------------------------------------
module window_median_filter #(
  parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = wmf_pkg::DEF_MAX_WINDOW
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  wmf_cfg_if.sink  cfg_i,
  wmf_pix_if.sink  pix_i,
  wmf_res_if.source res_o
);

  localparam int LINES   = MAX_WINDOW - 1;
  localparam int SW      = $clog2(LINES);
  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int N       = MAX_WINDOW * MAX_WINDOW;
  localparam int K_SMALL = wmf_pkg::K_SMALL;
  localparam int K_LARGE = (wmf_pkg::K_LARGE < MAX_WINDOW) ? wmf_pkg::K_LARGE : MAX_WINDOW;
  localparam int W_LIMIT = (MAX_WIDTH < wmf_pkg::SIZE_MAX) ? MAX_WIDTH : wmf_pkg::SIZE_MAX;
  localparam int W_RESET = (wmf_pkg::RST_WIDTH > W_LIMIT) ? W_LIMIT : wmf_pkg::RST_WIDTH;
  localparam int DW      = wmf_pkg::DIM_W;
  localparam int CW      = wmf_pkg::CFG_W;
  localparam int PW      = wmf_pkg::PIX_W;
  localparam logic [DW-1:0] KM1_SMALL = DW'(K_SMALL - 1);
  localparam logic [DW-1:0] KM1_LARGE = DW'(K_LARGE - 1);

  // (slot + off) mod LINES, with off below LINES
  function automatic logic [SW-1:0] line_idx(input logic [SW-1:0] slot,
                                             input int unsigned off);
    logic [SW:0] sum;
    sum = {1'b0, slot} + (SW+1)'(off);
    if (sum >= (SW+1)'(LINES)) begin
      sum = sum - (SW+1)'(LINES);
    end
    return sum[SW-1:0];
  endfunction

  // configuration
  logic [CW-1:0] width_q, height_q, w_wr, h_wr;
  logic          large_q;

  // frame position
  logic [DW-1:0] row_q, row_d, col_q, col_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [DW-1:0] r0, c0, c_eff, km1;
  logic [SW-1:0] slot0;
  logic [CW-1:0] c_inc, r_inc;
  logic          emit0;
  wmf_pkg::pos_t pos0;
  logic          pix_acc;
  logic [AW-1:0] mem_addr;

  // line store read stage
  logic          s1_v_q, s1_emit_q, s1_free;
  wmf_pkg::pos_t s1_pos_q;
  logic [PW-1:0] s1_pix_q;
  logic [SW-1:0] s1_slot_q;
  logic [PW-1:0] line_rd [LINES];

  // window stage
  logic          s2_v_q, s2_free, shift;
  wmf_pkg::pos_t s2_pos_q;
  logic [PW-1:0] col_small [MAX_WINDOW];
  logic [PW-1:0] col_large [MAX_WINDOW];
  logic [PW-1:0] col_in    [MAX_WINDOW];
  logic [PW-1:0] win       [N];
  logic          med_ready;
  wmf_pkg::res_t med_res;

  assign cfg_i.ready = 1'b1;

  // saturate sizes on write
  always_comb begin
    w_wr = cfg_i.data;
    if (w_wr < CW'(wmf_pkg::SIZE_MIN)) begin
      w_wr = CW'(wmf_pkg::SIZE_MIN);
    end else if (w_wr > CW'(W_LIMIT)) begin
      w_wr = CW'(W_LIMIT);
    end
    h_wr = cfg_i.data;
    if (h_wr < CW'(wmf_pkg::SIZE_MIN)) begin
      h_wr = CW'(wmf_pkg::SIZE_MIN);
    end else if (h_wr > CW'(wmf_pkg::SIZE_MAX)) begin
      h_wr = CW'(wmf_pkg::SIZE_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(W_RESET);
      height_q <= CW'(wmf_pkg::RST_HEIGHT);
      large_q  <= wmf_pkg::RST_WINDOW_SEL;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        wmf_pkg::CFG_IMAGE_WIDTH:   width_q  <= w_wr;
        wmf_pkg::CFG_IMAGE_HEIGHT:  height_q <= h_wr;
        wmf_pkg::CFG_WINDOW_SELECT: large_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign s2_free     = !s2_v_q || med_ready;
  assign shift       = s1_v_q && s2_free;
  assign s1_free     = !s1_v_q || s2_free;
  assign pix_i.ready = s1_free;

  always_comb begin
    km1 = large_q ? KM1_LARGE : KM1_SMALL;
    if (pix_i.start_of_frame) begin
      r0    = '0;
      c0    = '0;
      slot0 = '0;
    end else begin
      r0    = row_q;
      c0    = col_q;
      slot0 = slot_q;
    end
    c_eff = c0;
    if (32'(c0) >= MAX_WIDTH) begin
      c_eff = DW'(MAX_WIDTH - 1);
    end
    emit0 = (r0 >= km1) && (c_eff >= km1) &&
            ({1'b0, r0} < height_q) && ({1'b0, c_eff} < width_q);
    pos0.out_row       = r0 - km1;
    pos0.out_col       = c_eff - km1;
    pos0.last_of_frame = ({1'b0, r0} == height_q - CW'(1)) &&
                         ({1'b0, c_eff} == width_q - CW'(1));
    mem_addr = AW'(c_eff);

    // advance column, wrap into the next row, wrap the frame
    c_inc  = {1'b0, c_eff} + CW'(1);
    r_inc  = {1'b0, r0} + CW'(1);
    col_d  = c_inc[DW-1:0];
    row_d  = r0;
    slot_d = slot0;
    if (c_inc >= width_q) begin
      col_d = '0;
      if (r_inc >= height_q) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = r_inc[DW-1:0];
        slot_d = (slot0 == SW'(LINES - 1)) ? '0 : slot0 + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (pix_acc) begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
    end
  end

  for (genvar gl = 0; gl < LINES; gl++) begin : g_line
    wmf_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
    ) u_line_mem (
      .clk_i     (clk_i),
      .wr_en_i   (pix_acc && slot0 == SW'(gl)),
      .rd_en_i   (pix_acc),
      .addr_i    (mem_addr),
      .wr_data_i (pix_i.pixel),
      .rd_data_o (line_rd[gl])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= pix_i.valid;
      end
      // items that give no result end here, after their window shift
      if (s2_free) begin
        s2_v_q <= s1_v_q && s1_emit_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_emit_q <= emit0;
      s1_pos_q  <= pos0;
      s1_pix_q  <= pix_i.pixel;
      s1_slot_q <= slot0;
    end
    if (shift) begin
      s2_pos_q <= s1_pos_q;
    end
  end

  // incoming column: older rows from the line stores, newest row is the pixel
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      col_small[i] = '0;
      col_large[i] = '0;
      if (i == K_SMALL - 1) begin
        col_small[i] = s1_pix_q;
      end else if (i < K_SMALL - 1) begin
        for (int l = 0; l < LINES; l++) begin
          if (line_idx(s1_slot_q, LINES - (K_SMALL - 1 - i)) == SW'(l)) begin
            col_small[i] = col_small[i] | line_rd[l];
          end
        end
      end
      if (i == K_LARGE - 1) begin
        col_large[i] = s1_pix_q;
      end else if (i < K_LARGE - 1) begin
        for (int l = 0; l < LINES; l++) begin
          if (line_idx(s1_slot_q, LINES - (K_LARGE - 1 - i)) == SW'(l)) begin
            col_large[i] = col_large[i] | line_rd[l];
          end
        end
      end
      col_in[i] = large_q ? col_large[i] : col_small[i];
    end
  end

  for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_row
    for (genvar gj = 0; gj < MAX_WINDOW; gj++) begin : g_col
      logic [PW-1:0] right_val;
      if (gj < MAX_WINDOW - 1) begin : g_inner
        assign right_val = win[gi*MAX_WINDOW+gj+1];
      end else begin : g_edge
        assign right_val = '0;
      end
      wmf_cell #(
        .SRC_SMALL (wmf_pkg::cell_src(gi, gj, K_SMALL)),
        .SRC_LARGE (wmf_pkg::cell_src(gi, gj, K_LARGE))
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .large_i (large_q),
        .right_i (right_val),
        .col_i   (col_in[gi]),
        .value_o (win[gi*MAX_WINDOW+gj])
      );
    end
  end

  wmf_median #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .large_i     (large_q),
    .in_valid_i  (s2_v_q),
    .in_ready_o  (med_ready),
    .pos_i       (s2_pos_q),
    .win_i       (win),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .res_o       (med_res)
  );

  assign res_o.out_row       = med_res.pos.out_row;
  assign res_o.out_col       = med_res.pos.out_col;
  assign res_o.last_of_frame = med_res.pos.last_of_frame;
  assign res_o.median_value  = med_res.median_value;

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SW'(LINES - 1))
    else $error("line slot out of range");

  a_sof_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready && pix_i.start_of_frame) |=> !s1_emit_q)
    else $error("first pixel of a frame marked as completing a window");

  a_window_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !med_ready) |=> $stable(win[0]))
    else $error("window shifted under a stalled item");
`endif

endmodule

### rtl/wmf_line_mem.sv
// ----------------------------------------------------------------------------
// wmf_line_mem
// One line store: single-address pixel memory, read-first, registered read.
// ----------------------------------------------------------------------------
module wmf_line_mem #(
  parameter int DEPTH = wmf_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             addr_i,
  input  logic [wmf_pkg::PIX_W-1:0] wr_data_i,
  output logic [wmf_pkg::PIX_W-1:0] rd_data_o
);

  logic [wmf_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [wmf_pkg::PIX_W-1:0] rd_data_q;

  // read sees the old entry when the same address is written
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/wmf_cell.sv
// ----------------------------------------------------------------------------
// wmf_cell
// One window pixel register; on a shift it loads from its right neighbor,
// from the incoming column, or holds, depending on the window size.
// ----------------------------------------------------------------------------
module wmf_cell #(
  parameter wmf_pkg::cell_src_e SRC_SMALL = wmf_pkg::SRC_HOLD,
  parameter wmf_pkg::cell_src_e SRC_LARGE = wmf_pkg::SRC_HOLD
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic                      large_i,
  input  logic [wmf_pkg::PIX_W-1:0] right_i,
  input  logic [wmf_pkg::PIX_W-1:0] col_i,
  output logic [wmf_pkg::PIX_W-1:0] value_o
);

  wmf_pkg::cell_src_e        src;
  logic [wmf_pkg::PIX_W-1:0] value_d, value_q;

  always_comb begin
    src     = large_i ? SRC_LARGE : SRC_SMALL;
    value_d = value_q;
    if (shift_i) begin
      unique case (src)
        wmf_pkg::SRC_HOLD:  value_d = value_q;
        wmf_pkg::SRC_RIGHT: value_d = right_i;
        wmf_pkg::SRC_COL:   value_d = col_i;
        default:            value_d = value_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

### rtl/wmf_median.sv
// ----------------------------------------------------------------------------
// wmf_median
// Rank-select median of the window: pairwise compares, rank counts, then
// pick the element whose rank is the middle one. Three register stages.
// ----------------------------------------------------------------------------
module wmf_median #(
  parameter int MAX_WINDOW = wmf_pkg::DEF_MAX_WINDOW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      large_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  wmf_pkg::pos_t             pos_i,
  input  logic [wmf_pkg::PIX_W-1:0] win_i [MAX_WINDOW*MAX_WINDOW],
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output wmf_pkg::res_t             res_o
);

  localparam int N       = MAX_WINDOW * MAX_WINDOW;
  localparam int NP      = N * (N - 1) / 2;
  localparam int CW      = $clog2(N);
  localparam int K_LARGE = (wmf_pkg::K_LARGE < MAX_WINDOW) ? wmf_pkg::K_LARGE : MAX_WINDOW;
  localparam logic [CW-1:0] MID_SMALL = CW'(wmf_pkg::K_SMALL * wmf_pkg::K_SMALL / 2);
  localparam logic [CW-1:0] MID_LARGE = CW'(K_LARGE * K_LARGE / 2);

  logic [N-1:0] act;

  logic [NP-1:0]             le_d, le_q;
  logic                      s3_v_q, s4_v_q, out_v_q;
  logic                      s3_free, s4_free, out_free;
  logic [wmf_pkg::PIX_W-1:0] val3_q [N];
  logic [wmf_pkg::PIX_W-1:0] val4_q [N];
  logic [CW-1:0]             rank_d [N];
  logic [CW-1:0]             rank_q [N];
  wmf_pkg::pos_t             pos3_q, pos4_q;
  logic [CW-1:0]             mid;
  logic [wmf_pkg::PIX_W-1:0] med;
  wmf_pkg::res_t             res_q;

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        act[i*MAX_WINDOW+j] = large_i ? (i < K_LARGE && j < K_LARGE)
                                      : (i < wmf_pkg::K_SMALL && j < wmf_pkg::K_SMALL);
      end
    end
  end

  assign out_free   = !out_v_q || out_ready_i;
  assign s4_free    = !s4_v_q || out_free;
  assign s3_free    = !s3_v_q || s4_free;
  assign in_ready_o = s3_free;

  // lower triangle only: entry (e, f) with f < e is win[f] <= win[e]
  always_comb begin
    le_d = '0;
    for (int e = 1; e < N; e++) begin
      for (int f = 0; f < e; f++) begin
        le_d[e*(e-1)/2+f] = (win_i[f] <= win_i[e]);
      end
    end
  end

  // rank = number of active elements ordered below, ties broken by position
  always_comb begin
    logic [N-1:0] below;
    for (int e = 0; e < N; e++) begin
      below = '0;
      for (int f = 0; f < N; f++) begin
        if (f < e) begin
          below[f] = le_q[e*(e-1)/2+f] && act[f];
        end else if (f > e) begin
          below[f] = !le_q[f*(f-1)/2+e] && act[f];
        end
      end
      rank_d[e] = CW'($countones(below));
    end
  end

  always_comb begin
    mid = large_i ? MID_LARGE : MID_SMALL;
    med = '0;
    for (int e = 0; e < N; e++) begin
      if (act[e] && rank_q[e] == mid) begin
        med = med | val4_q[e];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s3_free) begin
        s3_v_q <= in_valid_i;
      end
      if (s4_free) begin
        s4_v_q <= s3_v_q;
      end
      if (out_free) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free && in_valid_i) begin
      le_q   <= le_d;
      pos3_q <= pos_i;
      val3_q <= win_i;
    end
    if (s4_free && s3_v_q) begin
      rank_q <= rank_d;
      pos4_q <= pos3_q;
      val4_q <= val3_q;
    end
    if (out_free && s4_v_q) begin
      res_q.pos          <= pos4_q;
      res_q.median_value <= med;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the window median filter. Raster frames of random
// size, content and window are streamed through valid/ready channels with
// random stalls on both sides. Every accepted pixel also steps an in-bench
// copy of the line stores, window and median selection, and each filtered
// item that leaves the block is compared field by field with the oldest
// expected one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LINES       = wmf_pkg::DEF_MAX_WINDOW - 1;
  localparam int SETTLE_CYC  = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_ITEMS  = 450;

  typedef struct packed {
    logic [wmf_pkg::PIX_W-1:0] pixel;
    logic                      sof;
  } pix_item_t;

  typedef enum int {STYLE_FULL, STYLE_EXTREME, STYLE_TIES} pix_style_e;

  logic clk = 1'b0;
  logic rst_n;

  wmf_cfg_if cfg_if ();
  wmf_pix_if pix_if ();
  wmf_res_if res_if ();

  window_median_filter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  always #10 clk = ~clk;

  // filter state mirrored in the bench
  bit [wmf_pkg::PIX_W-1:0]   line_mem [LINES][wmf_pkg::DEF_MAX_WIDTH];
  bit [wmf_pkg::PIX_W-1:0]   win_mem  [wmf_pkg::DEF_MAX_WINDOW][wmf_pkg::DEF_MAX_WINDOW];
  int unsigned               col_pos, row_pos;
  logic [wmf_pkg::CFG_W-1:0] cur_width, cur_height;
  logic                      cur_win5;
  wmf_pkg::res_t             median_q [$];

  pix_item_t                 pix_pending_q [$];
  logic [wmf_pkg::PIX_W-1:0] seed_img [25];
  int unsigned               pix_sent_cnt, pix_taken_cnt, cfg_taken_cnt, err_cnt;
  int unsigned               cycle_cnt = 0;
  int                        pix_gap, res_stall;
  bit                        idle_on = 1'b1;

  function automatic int unsigned sat_size(input int unsigned v);
    if (v < wmf_pkg::SIZE_MIN) return wmf_pkg::SIZE_MIN;
    if (v > wmf_pkg::SIZE_MAX) return wmf_pkg::SIZE_MAX;
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Advance the mirrored window by one pixel and queue the median it yields.
  task automatic slide_window(input logic [wmf_pkg::PIX_W-1:0] pix, input logic sof);
    int unsigned               w, h, k, r, c, slot, n;
    int                        j;
    logic [wmf_pkg::PIX_W-1:0] x;
    logic [wmf_pkg::PIX_W-1:0] col_v [wmf_pkg::DEF_MAX_WINDOW];
    logic [wmf_pkg::PIX_W-1:0] vals [wmf_pkg::DEF_MAX_WINDOW*wmf_pkg::DEF_MAX_WINDOW];
    wmf_pkg::res_t             res;
    w = sat_size(cur_width);
    if (w > wmf_pkg::DEF_MAX_WIDTH) w = wmf_pkg::DEF_MAX_WIDTH;
    h = sat_size(cur_height);
    k = cur_win5 ? wmf_pkg::K_LARGE : wmf_pkg::K_SMALL;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = (col_pos >= wmf_pkg::DEF_MAX_WIDTH) ? wmf_pkg::DEF_MAX_WIDTH - 1 : col_pos;
    slot = r % LINES;
    // oldest row on top, incoming pixel at the bottom
    for (int i = 0; i < k - 1; i++) begin
      col_v[i] = line_mem[(slot + LINES - (k - 1 - i)) % LINES][c];
    end
    col_v[k-1] = pix;
    line_mem[slot][c] = pix;
    for (int i = 0; i < k; i++) begin
      for (int jj = 0; jj < k - 1; jj++) begin
        win_mem[i][jj] = win_mem[i][jj+1];
      end
      win_mem[i][k-1] = col_v[i];
    end
    if (r >= k - 1 && c >= k - 1 && r < h && c < w) begin
      n = 0;
      for (int i = 0; i < k; i++) begin
        for (int jj = 0; jj < k; jj++) begin
          x = win_mem[i][jj];
          j = n;
          while (j > 0 && vals[j-1] > x) begin
            vals[j] = vals[j-1];
            j--;
          end
          vals[j] = x;
          n++;
        end
      end
      res.pos.out_row       = wmf_pkg::DIM_W'(r - (k - 1));
      res.pos.out_col       = wmf_pkg::DIM_W'(c - (k - 1));
      res.pos.last_of_frame = (r == h - 1 && c == w - 1);
      res.median_value      = vals[n/2];
      median_q.push_back(res);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin : monitor
    wmf_pkg::res_t want;
    if (rst_n) begin
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
        case (cfg_if.index)
          wmf_pkg::CFG_IMAGE_WIDTH:   cur_width  = cfg_if.data;
          wmf_pkg::CFG_IMAGE_HEIGHT:  cur_height = cfg_if.data;
          wmf_pkg::CFG_WINDOW_SELECT: cur_win5   = cfg_if.data[0];
          default: ;
        endcase
        cfg_taken_cnt++;
      end
      if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
        slide_window(pix_if.pixel, pix_if.start_of_frame);
        pix_taken_cnt++;
      end
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        if (median_q.size() == 0) begin
          $display("%0t: expected no item, got row %0d col %0d median %0d last %0b",
                   $time, res_if.out_row, res_if.out_col, res_if.median_value,
                   res_if.last_of_frame);
          err_cnt++;
        end else begin
          want = median_q.pop_front();
          check_field("out_row", 16'(want.pos.out_row), 16'(res_if.out_row));
          check_field("out_col", 16'(want.pos.out_col), 16'(res_if.out_col));
          check_field("median_value", 16'(want.median_value), 16'(res_if.median_value));
          check_field("last_of_frame", 16'(want.pos.last_of_frame),
                      16'(res_if.last_of_frame));
        end
      end
    end
  end

  always @(negedge clk) begin : feed_pixels
    pix_item_t item;
    // hold the current item until it is taken
    if (rst_n && !(pix_if.valid && pix_sent_cnt != pix_taken_cnt)) begin
      if (pix_gap > 0) begin
        pix_gap--;
        pix_if.valid <= 1'b0;
      end else if (pix_pending_q.size() != 0) begin
        item = pix_pending_q.pop_front();
        pix_if.pixel          <= item.pixel;
        pix_if.start_of_frame <= item.sof;
        pix_if.valid          <= 1'b1;
        pix_sent_cnt++;
        if (idle_on && $urandom_range(0, 5) == 0) pix_gap = $urandom_range(1, 3);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : accept_results
    if (rst_n) begin
      if (res_stall > 0) begin
        res_stall--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res_stall = $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("window_median_filter: mismatch");
    $finish;
  end

  // Call at a falling edge; returns at a falling edge with the channel idle.
  task automatic program_regs(input int unsigned w, input int unsigned h, input bit win5);
    logic [wmf_pkg::CFG_IDX_W-1:0] idx [3];
    int unsigned                   val [3];
    int unsigned                   seen;
    idx = '{wmf_pkg::CFG_IMAGE_WIDTH, wmf_pkg::CFG_IMAGE_HEIGHT,
            wmf_pkg::CFG_WINDOW_SELECT};
    val = '{w, h, win5 ? 1 : 0};
    for (int i = 0; i < 3; i++) begin
      cfg_if.index <= idx[i];
      cfg_if.data  <= wmf_pkg::CFG_W'(val[i]);
      cfg_if.valid <= 1'b1;
      seen = cfg_taken_cnt;
      do @(negedge clk); while (cfg_taken_cnt == seen);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every pixel is in and every median is out, then let the pipe empty.
  task automatic settle();
    while (pix_pending_q.size() != 0 || pix_sent_cnt != pix_taken_cnt ||
           median_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic queue_frame(input int unsigned count, input bit lead_sof,
                             input pix_style_e style, input bit stray);
    pix_item_t item;
    for (int unsigned i = 0; i < count; i++) begin
      case (style)
        STYLE_EXTREME: item.pixel = $urandom_range(0, 1) ? 8'hff : 8'h00;
        STYLE_TIES:    item.pixel = wmf_pkg::PIX_W'($urandom_range(100, 103));
        default:       item.pixel = wmf_pkg::PIX_W'($urandom);
      endcase
      item.sof = (i == 0) ? lead_sof : (stray && $urandom_range(0, 63) == 0);
      pix_pending_q.push_back(item);
    end
  endtask

  initial begin : stimulus
    int unsigned w, h, n, full, fed, phase, frames;
    bit          win5, lead;
    pix_style_e  style;
    pix_item_t   item;
    rst_n = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.start_of_frame = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = wmf_pkg::CFG_IMAGE_WIDTH;
    cfg_if.data = '0;
    cur_width  = wmf_pkg::CFG_W'(wmf_pkg::RST_WIDTH);
    cur_height = wmf_pkg::CFG_W'(wmf_pkg::RST_HEIGHT);
    cur_win5   = wmf_pkg::RST_WINDOW_SEL;
    seed_img = '{8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
                 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
                 8'd128, 8'd128, 8'd127, 8'd129, 8'd128,
                 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
                 8'd255, 8'd254, 8'd1,   8'd2,   8'd255};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // smallest image: sizes below range saturate to 5x5
    program_regs(0, 4, 1'b0);
    for (int i = 0; i < 25; i++) begin
      item.pixel = seed_img[i];
      item.sof   = (i == 0);
      pix_pending_q.push_back(item);
    end
    settle();

    fed = 0;
    phase = 0;
    while (fed < RAND_ITEMS) begin
      case ($urandom_range(0, 15))
        0:       w = 2047;
        1, 2:    w = $urandom_range(0, 4);
        default: w = $urandom_range(5, 12);
      endcase
      case ($urandom_range(0, 15))
        0:       h = 2047;
        1:       h = $urandom_range(0, 4);
        default: h = $urandom_range(5, 9);
      endcase
      win5 = $urandom_range(0, 1);
      program_regs(w, h, win5);
      full = sat_size(w) * sat_size(h);
      frames = $urandom_range(1, 3);
      lead = 1'b1;
      for (int f = 0; f < frames; f++) begin
        style = STYLE_FULL;
        if ($urandom_range(0, 3) == 0) style = pix_style_e'($urandom_range(1, 2));
        if (full > 200) n = $urandom_range(40, 120);
        else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, full - 1);
        else n = full;
        if (phase == 0 && f == 0) begin
          // stop feeding mid-frame until every median is out
          n = (full > 200) ? 60 : full;
          queue_frame(n / 2, lead, style, 1'b1);
          settle();
          queue_frame(n - n / 2, 1'b0, style, 1'b1);
        end else begin
          queue_frame(n, lead, style, 1'b1);
        end
        fed += n;
        // after a complete frame, let the counters wrap on their own half the time
        lead = (n < full) || $urandom_range(0, 1);
      end
      settle();
      phase++;
    end

    idle_on = 1'b0;
    program_regs(9, 7, 1'b1);
    queue_frame(2 * 9 * 7, 1'b1, STYLE_FULL, 1'b0);
    settle();

    if (err_cnt == 0) begin
      $display("window_median_filter: match");
    end else begin
      $display("window_median_filter: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/wmf_pkg.sv
rtl/wmf_if.sv
rtl/wmf_line_mem.sv
rtl/wmf_cell.sv
rtl/wmf_median.sv
rtl/window_median_filter.sv
dv/tb_top.sv
